### rtl/core/midi_message_byte_encoder_defines.svh
// Assertion macros shared by the MIDI byte encoder modules.
`ifndef MIDI_MESSAGE_BYTE_ENCODER_DEFINES_SVH
`define MIDI_MESSAGE_BYTE_ENCODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MMBE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mmbe assertion failed");

// Next-cycle implication, checked out of reset.
`define MMBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mmbe assertion failed");

`endif

### rtl/core/mmbe_pkg.sv
// Package: types, codes and helpers for the MIDI message byte encoder.
package mmbe_pkg;

    localparam logic [7:0] T_SX_START = 8'h70;
    localparam logic [7:0] T_QFRAME   = 8'h71;
    localparam logic [7:0] T_SONGPOS  = 8'h72;
    localparam logic [7:0] T_SONGSEL  = 8'h73;
    localparam logic [7:0] T_TUNE     = 8'h76;
    localparam logic [7:0] T_SX_STOP  = 8'h77;
    localparam logic [7:0] T_RESET    = 8'h7F;
    localparam logic [7:0] T_SX_DATA  = 8'h80;
    localparam logic [7:0] T_BEND     = 8'h60;
    localparam logic [7:0] T_PROGRAM  = 8'h40;
    localparam logic [7:0] T_PRESSURE = 8'h50;
    localparam logic [6:0] TYPE_NONE  = 7'h7F;

    localparam logic [7:0] B_SX_START = 8'hF0;
    localparam logic [7:0] B_QFRAME   = 8'hF1;
    localparam logic [7:0] B_SONGPOS  = 8'hF2;
    localparam logic [7:0] B_SONGSEL  = 8'hF3;
    localparam logic [7:0] B_TUNE     = 8'hF6;
    localparam logic [7:0] B_SX_STOP  = 8'hF7;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_TYPE    = 2'd1;
    localparam logic [1:0] ERR_SX_DATA = 2'd2;

    localparam int unsigned MAX_RES = 4;

    typedef struct packed {
        logic [7:0]  msg_type;
        logic [4:0]  channel;
        logic [6:0]  data_a;
        logic [6:0]  data_b;
        logic [13:0] bend_value;
        logic [13:0] song_position;
        logic [7:0]  sysex_data;
        logic [8:0]  sysex_seq;
        logic [14:0] stop_length;
        logic        stop_overflowed;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       to_priority;
        logic       warning;
        logic [1:0] error_code;
    } t_rec;

    typedef struct packed {
        t_rec [MAX_RES-1:0] recs;
        logic [1:0]         last_idx;
    } t_list;

    function automatic t_rec mk_byte(input logic [7:0] b, input logic warn);
        t_rec r;
        r = '0;
        r.out_byte = b;
        r.has_byte = 1'b1;
        r.warning  = warn;
        return r;
    endfunction

    function automatic t_rec mk_err(input logic [1:0] code);
        t_rec r;
        r = '0;
        r.error_code = code;
        return r;
    endfunction

endpackage

### rtl/core/midi_message_byte_encoder.sv
// A message accepted into the input register has its byte list loaded into the
// result register when that register can take it, and its first byte is shown from there.
// Each message gives one to four result records; the result register sends one
// byte a cycle while i_ready is high, and the input register holds the next message.
// Reset (i_rst_n low, synchronous): idle, no running status, SysEx count
// cleared, realtime_first cleared; no configuration sweep is needed.
module midi_message_byte_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_msg_type,
    input  logic [4:0]  i_channel,
    input  logic [6:0]  i_data_a,
    input  logic [6:0]  i_data_b,
    input  logic signed [13:0] i_bend_value,
    input  logic [13:0] i_song_position,
    input  logic [7:0]  i_sysex_data,
    input  logic [8:0]  i_sysex_seq,
    input  logic [14:0] i_stop_length,
    input  logic        i_stop_overflowed,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_has_byte,
    output logic        o_to_priority,
    output logic        o_warning,
    output logic [1:0]  o_error_code,
    output logic        o_last
);

    mmbe_pkg::t_item item;
    mmbe_pkg::t_list list;
    mmbe_pkg::t_rec  rec;
    logic            list_valid;
    logic            list_ready;

    assign item.msg_type        = i_msg_type;
    assign item.channel         = i_channel;
    assign item.data_a          = i_data_a;
    assign item.data_b          = i_data_b;
    assign item.bend_value      = i_bend_value;
    assign item.song_position   = i_song_position;
    assign item.sysex_data      = i_sysex_data;
    assign item.sysex_seq       = i_sysex_seq;
    assign item.stop_length     = i_stop_length;
    assign item.stop_overflowed = i_stop_overflowed;

    assign o_cfg_ready = 1'b1;

    mmbe_encoder u_encoder (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_item       (item),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_list_valid (list_valid),
        .i_list_ready (list_ready),
        .o_list       (list)
    );

    mmbe_serializer u_serializer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_list_valid (list_valid),
        .o_list_ready (list_ready),
        .i_list       (list),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_rec        (rec),
        .o_last       (o_last)
    );

    assign o_out_byte    = rec.out_byte;
    assign o_has_byte    = rec.has_byte;
    assign o_to_priority = rec.to_priority;
    assign o_warning     = rec.warning;
    assign o_error_code  = rec.error_code;

endmodule

### rtl/core/mmbe_encoder.sv
// Input register, running status and SysEx state, and per-message byte list.
`include "midi_message_byte_encoder_defines.svh"

module mmbe_encoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  mmbe_pkg::t_item      i_item,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_data,
    output logic                 o_list_valid,
    input  logic                 i_list_ready,
    output mmbe_pkg::t_list      o_list
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_RUN,
        MODE_SYSEX
    } t_mode;

    t_mode           r_mode, n_mode;
    logic [6:0]      r_rtype, n_rtype;
    logic [4:0]      r_rchan, n_rchan;
    logic [14:0]     r_sx_count, n_sx_count;
    logic            r_sx_over, n_sx_over;
    logic            r_rt_first;
    logic            r_in_valid;
    mmbe_pkg::t_item r_in;

    logic            consume;
    logic [7:0]      t;
    logic [4:0]      ch;
    logic            is_rt;
    logic            is_chan;
    logic            pre;
    mmbe_pkg::t_rec  b0, b1, b2;
    logic [1:0]      body_last;
    logic [7:0]      cd0, cd1;
    logic            cd_two;
    logic [3:0]      nib;

    assign consume      = r_in_valid && i_list_ready;
    assign o_ready      = !r_in_valid || i_list_ready;
    assign o_list_valid = r_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_rt_first <= 1'b0;
            r_mode     <= MODE_IDLE;
            r_rtype    <= mmbe_pkg::TYPE_NONE;
            r_rchan    <= '0;
            r_sx_count <= '0;
            r_sx_over  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_rt_first <= i_cfg_data;
            end
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (consume) begin
                r_mode     <= n_mode;
                r_rtype    <= n_rtype;
                r_rchan    <= n_rchan;
                r_sx_count <= n_sx_count;
                r_sx_over  <= n_sx_over;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_item;
        end
    end

    // data bytes of a channel message
    always_comb begin
        cd0    = {1'b0, r_in.data_a};
        cd1    = {1'b0, r_in.data_b};
        cd_two = 1'b1;
        if (r_in.msg_type == mmbe_pkg::T_BEND) begin
            cd0 = {1'b0, r_in.bend_value[6:0]};
            cd1 = {1'b0, ~r_in.bend_value[13], r_in.bend_value[12:7]};
        end else if (r_in.msg_type == mmbe_pkg::T_PROGRAM ||
                     r_in.msg_type == mmbe_pkg::T_PRESSURE) begin
            cd_two = 1'b0;
        end
    end

    always_comb begin
        t          = r_in.msg_type;
        ch         = r_in.channel;
        nib        = ch[3:0] - 4'd1;
        is_rt      = (t == 8'h78) || (t == 8'h7A) || (t == 8'h7B) || (t == 8'h7C) ||
                     (t == 8'h7E) || (t == mmbe_pkg::T_RESET);
        is_chan    = (t[7] == 1'b0) && (t[6:4] != 3'd7) && (t[3:0] == 4'd0);
        n_mode     = r_mode;
        n_rtype    = r_rtype;
        n_rchan    = r_rchan;
        n_sx_count = r_sx_count;
        n_sx_over  = r_sx_over;
        pre        = 1'b0;
        b0         = '0;
        b1         = '0;
        b2         = '0;
        body_last  = 2'd0;

        if (is_rt) begin
            b0             = mmbe_pkg::mk_byte({1'b1, t[6:0]}, 1'b0);
            b0.to_priority = r_rt_first;
            if (t == mmbe_pkg::T_RESET) begin
                n_mode     = MODE_IDLE;
                n_rtype    = mmbe_pkg::TYPE_NONE;
                n_rchan    = '0;
                n_sx_count = '0;
                n_sx_over  = 1'b0;
            end
        end else if (r_mode == MODE_SYSEX && t == mmbe_pkg::T_SX_DATA) begin
            b0 = mmbe_pkg::mk_byte({1'b0, r_in.sysex_data[6:0]},
                                   r_in.sysex_seq != r_sx_count[8:0]);
            n_sx_count = r_sx_count + 15'd1;
            if (r_sx_count == 15'h7FFF) begin
                n_sx_over = 1'b1;
            end
        end else if (r_mode == MODE_SYSEX && t == mmbe_pkg::T_SX_STOP) begin
            b0 = mmbe_pkg::mk_byte(mmbe_pkg::B_SX_STOP,
                                   (r_in.stop_length != r_sx_count) ||
                                   (r_in.stop_overflowed != r_sx_over));
            n_sx_count = '0;
            n_sx_over  = 1'b0;
            n_mode     = MODE_IDLE;
        end else begin
            // SysEx interrupted: close it first
            pre = (r_mode == MODE_SYSEX);
            if (pre) begin
                n_sx_count = '0;
                n_sx_over  = 1'b0;
            end
            if (r_mode == MODE_RUN && t == {1'b0, r_rtype} && ch == r_rchan) begin
                b0        = mmbe_pkg::mk_byte(cd0, 1'b0);
                b1        = mmbe_pkg::mk_byte(cd1, 1'b0);
                body_last = {1'b0, cd_two};
            end else begin
                n_rtype = mmbe_pkg::TYPE_NONE;
                n_rchan = '0;
                n_mode  = MODE_IDLE;
                if (is_chan) begin
                    b0        = mmbe_pkg::mk_byte({1'b1, t[6:4], nib}, 1'b0);
                    b1        = mmbe_pkg::mk_byte(cd0, 1'b0);
                    b2        = mmbe_pkg::mk_byte(cd1, 1'b0);
                    body_last = cd_two ? 2'd2 : 2'd1;
                    n_rtype   = t[6:0];
                    n_rchan   = ch;
                    n_mode    = MODE_RUN;
                end else if (t == mmbe_pkg::T_SX_START) begin
                    b0         = mmbe_pkg::mk_byte(mmbe_pkg::B_SX_START, 1'b0);
                    n_sx_count = '0;
                    n_sx_over  = 1'b0;
                    n_mode     = MODE_SYSEX;
                end else if (t == mmbe_pkg::T_SX_STOP) begin
                    b0 = mmbe_pkg::mk_err(mmbe_pkg::ERR_NONE);
                end else if (t == mmbe_pkg::T_QFRAME) begin
                    b0        = mmbe_pkg::mk_byte(mmbe_pkg::B_QFRAME, 1'b0);
                    b1        = mmbe_pkg::mk_byte({r_in.data_a[3:0], r_in.data_b[3:0]}, 1'b0);
                    body_last = 2'd1;
                end else if (t == mmbe_pkg::T_SONGPOS) begin
                    b0        = mmbe_pkg::mk_byte(mmbe_pkg::B_SONGPOS, 1'b0);
                    b1        = mmbe_pkg::mk_byte({1'b0, r_in.song_position[6:0]}, 1'b0);
                    b2        = mmbe_pkg::mk_byte({1'b0, r_in.song_position[13:7]}, 1'b0);
                    body_last = 2'd2;
                end else if (t == mmbe_pkg::T_SONGSEL) begin
                    b0        = mmbe_pkg::mk_byte(mmbe_pkg::B_SONGSEL, 1'b0);
                    b1        = mmbe_pkg::mk_byte({1'b0, r_in.data_a}, 1'b0);
                    body_last = 2'd1;
                end else if (t == mmbe_pkg::T_TUNE) begin
                    b0 = mmbe_pkg::mk_byte(mmbe_pkg::B_TUNE, 1'b0);
                end else if (t == mmbe_pkg::T_SX_DATA) begin
                    b0 = mmbe_pkg::mk_err(mmbe_pkg::ERR_SX_DATA);
                end else begin
                    b0 = mmbe_pkg::mk_err(mmbe_pkg::ERR_TYPE);
                end
            end
        end

        o_list.recs[0]  = pre ? mmbe_pkg::mk_byte(mmbe_pkg::B_SX_STOP, 1'b1) : b0;
        o_list.recs[1]  = pre ? b0 : b1;
        o_list.recs[2]  = pre ? b1 : b2;
        o_list.recs[3]  = b2;
        o_list.last_idx = body_last + {1'b0, pre};
    end

    `MMBE_ASSERT_NOW(a_rtype_none, i_clk, i_rst_n, r_mode != MODE_RUN, r_rtype == mmbe_pkg::TYPE_NONE)
    `MMBE_ASSERT_NOW(a_rtype_chan, i_clk, i_rst_n, r_mode == MODE_RUN, (r_rtype[3:0] == 4'd0) && (r_rtype[6:4] != 3'd7))
    `MMBE_ASSERT_NOW(a_count_sysex, i_clk, i_rst_n, (r_sx_count != '0) || r_sx_over, r_mode == MODE_SYSEX)

endmodule

### rtl/core/mmbe_serializer.sv
// Result register: holds one message's byte list and sends it a byte per cycle while i_ready is high.
`include "midi_message_byte_encoder_defines.svh"

module mmbe_serializer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_list_valid,
    output logic            o_list_ready,
    input  mmbe_pkg::t_list i_list,
    output logic            o_valid,
    input  logic            i_ready,
    output mmbe_pkg::t_rec  o_rec,
    output logic            o_last
);

    logic                                r_busy;
    logic [1:0]                          r_idx;
    logic [1:0]                          r_last_idx;
    mmbe_pkg::t_rec [mmbe_pkg::MAX_RES-1:0] r_recs;
    logic                                pop;

    assign o_valid      = r_busy;
    assign o_rec        = r_recs[r_idx];
    assign o_last       = (r_idx == r_last_idx);
    assign pop          = r_busy && i_ready;
    assign o_list_ready = !r_busy || (pop && o_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_list_valid && o_list_ready) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (pop) begin
            if (o_last) begin
                r_busy <= 1'b0;
            end
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_list_valid && o_list_ready) begin
            r_recs     <= i_list.recs;
            r_last_idx <= i_list.last_idx;
        end
    end

    `MMBE_ASSERT_NEXT(a_stay_busy, i_clk, i_rst_n, r_busy && !o_last, r_busy)
    `MMBE_ASSERT_NOW(a_idx_range, i_clk, i_rst_n, r_busy, r_idx <= r_last_idx)
    `MMBE_ASSERT_NOW(a_ready_idle, i_clk, i_rst_n, !r_busy, o_list_ready)

endmodule
